// File: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion lbl failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion lbl failed");

`endif

// File: src/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Types and constants of the byte-level I2C master engine.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    // Command codes
    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_STOP    = 3'd1;
    localparam logic [2:0] OP_WRITE   = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_ACK     = 3'd4;
    localparam logic [2:0] OP_NACK    = 3'd5;
    localparam logic [2:0] OP_WAITACK = 3'd6;

    // Half period after reset, in engine steps (tick requests)
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;

    // One input tick
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] write_data;
        logic       sda_in;
    } in_item_t;

    // One result tick
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_byte;
        logic       ack_received;
    } out_item_t;

endpackage

// File: src/i2cbm_engine.sv
// ----------------------------------------------------------------------------
// i2cbm_engine
// Command sequencer state and next-state logic, advanced one tick per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cbm_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    input  logic                 step,
    input  i2cbm_pkg::in_item_t  item,
    output i2cbm_pkg::out_item_t result
);

    // Phase codes
    localparam logic [4:0] PH_0    = 5'd0;
    localparam logic [4:0] PH_1    = 5'd1;
    localparam logic [4:0] PH_2    = 5'd2;
    localparam logic [4:0] PH_3    = 5'd3;
    localparam logic [4:0] PH_4    = 5'd4;
    localparam logic [4:0] PH_IDLE = 5'd31;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    logic [15:0] half_reg;
    logic [4:0]  phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [15:0] delay_reg, delay_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_reg, ack_next;
    logic [7:0]  hold_reg, hold_next;
    logic        run;
    logic        done;
    logic [3:0]  bit_inc;

    // Hold the half period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= i2cbm_pkg::HALF_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            half_reg <= cfg_wdata;
        end
    end

    // Start a command or count down, then run the action of the phase
    always_comb
    begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        delay_next = delay_reg;
        shift_next = shift_reg;
        cmd_next   = cmd_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        hold_next  = hold_reg;
        run        = 1'b0;
        done       = 1'b0;
        bit_inc    = bit_reg + 4'd1;

        if (phase_reg == PH_IDLE)
        begin
            if (item.cmd_valid && (item.opcode <= i2cbm_pkg::OP_WAITACK))
            begin
                cmd_next   = item.opcode;
                phase_next = PH_0;
                bit_next   = 4'd0;
                shift_next = (item.opcode == i2cbm_pkg::OP_WRITE) ? item.write_data : 8'd0;
                run        = 1'b1;
            end
        end
        else if (delay_reg > 16'd1)
        begin
            delay_next = delay_reg - 16'd1;
        end
        else
        begin
            run = 1'b1;
        end

        bit_inc = bit_next + 4'd1;

        if (run)
        begin
            unique case (cmd_next)
                i2cbm_pkg::OP_START:
                begin
                    unique case (phase_next)
                        PH_0:    begin sda_next = 1'b1; scl_next = 1'b1; phase_next = PH_1; end
                        PH_1:    begin sda_next = 1'b0; phase_next = PH_2; end
                        PH_2:    begin scl_next = 1'b0; phase_next = PH_3; end
                        default: begin sda_next = 1'b1; phase_next = PH_IDLE; end
                    endcase
                end
                i2cbm_pkg::OP_STOP:
                begin
                    unique case (phase_next)
                        PH_0:    begin sda_next = 1'b0; scl_next = 1'b0; phase_next = PH_1; end
                        PH_1:    begin scl_next = 1'b1; phase_next = PH_2; end
                        PH_2:    begin sda_next = 1'b0; phase_next = PH_3; end
                        default: begin sda_next = 1'b1; phase_next = PH_IDLE; end
                    endcase
                end
                i2cbm_pkg::OP_ACK, i2cbm_pkg::OP_NACK:
                begin
                    unique case (phase_next)
                        PH_0:
                        begin
                            sda_next   = (cmd_next == i2cbm_pkg::OP_NACK);
                            scl_next   = 1'b0;
                            phase_next = PH_1;
                        end
                        PH_1:    begin scl_next = 1'b1; phase_next = PH_2; end
                        default: begin scl_next = 1'b0; phase_next = PH_IDLE; end
                    endcase
                end
                i2cbm_pkg::OP_WAITACK:
                begin
                    unique case (phase_next)
                        PH_0:    begin scl_next = 1'b0; phase_next = PH_1; end
                        PH_1:    begin sda_next = 1'b1; phase_next = PH_2; end
                        PH_2:    begin scl_next = 1'b1; phase_next = PH_3; end
                        default:
                        begin
                            ack_next   = !item.sda_in;
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                i2cbm_pkg::OP_WRITE:
                begin
                    unique case (phase_next)
                        PH_0:    begin scl_next = 1'b0; phase_next = PH_1; end
                        PH_1:    begin sda_next = shift_next[7]; phase_next = PH_2; end
                        PH_2:    begin scl_next = 1'b1; phase_next = PH_3; end
                        PH_3:
                        begin
                            scl_next   = 1'b0;
                            shift_next = {shift_next[6:0], 1'b0};
                            bit_next   = bit_inc;
                            phase_next = (bit_inc < BITS_PER_BYTE) ? PH_1 : PH_4;
                        end
                        default: begin scl_next = 1'b0; phase_next = PH_IDLE; end
                    endcase
                end
                i2cbm_pkg::OP_READ:
                begin
                    unique case (phase_next)
                        PH_0:    begin sda_next = 1'b1; scl_next = 1'b0; phase_next = PH_1; end
                        PH_1:    begin scl_next = 1'b1; phase_next = PH_2; end
                        PH_2:
                        begin
                            shift_next = {shift_next[6:0], item.sda_in};
                            scl_next   = 1'b0;
                            bit_next   = bit_inc;
                            phase_next = (bit_inc < BITS_PER_BYTE) ? PH_0 : PH_3;
                        end
                        PH_3:    begin scl_next = 1'b0; phase_next = PH_4; end
                        default: begin hold_next = shift_next; phase_next = PH_IDLE; end
                    endcase
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // Reload the spacing counter, a zero half period acts as one
            if (phase_next == PH_IDLE)
            begin
                done       = 1'b1;
                delay_next = 16'd0;
            end
            else
            begin
                delay_next = (half_reg != 16'd0) ? half_reg : 16'd1;
            end
        end
    end

    // Advance the state on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bit_reg   <= 4'd0;
            delay_reg <= 16'd0;
            shift_reg <= 8'd0;
            cmd_reg   <= i2cbm_pkg::OP_START;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            hold_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            delay_reg <= delay_next;
            shift_reg <= shift_next;
            cmd_reg   <= cmd_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            hold_reg  <= hold_next;
        end
    end

    // Drive the result of this tick
    always_comb
    begin
        result.scl_out      = scl_next;
        result.sda_out      = sda_next;
        result.busy_res     = (phase_next != PH_IDLE);
        result.done_res     = done;
        result.rd_byte      = hold_next;
        result.ack_received = ack_next;
    end

    `ASSERT_CLK(a_done_goes_idle, clk, rst_n, (step && done) |=> (phase_reg == PH_IDLE))
    `ASSERT_NEVER(a_idle_no_delay, clk, rst_n, (phase_reg == PH_IDLE) && (delay_reg != 16'd0))
    `ASSERT_NEVER(a_bit_range, clk, rst_n, bit_reg > BITS_PER_BYTE)

endmodule

// File: src/i2c_byte_master.sv
// ----------------------------------------------------------------------------
// i2c_byte_master
// Byte-level I2C master: input register, engine step, result register.
// ----------------------------------------------------------------------------
// A tick request is held in the input register, then its result in the result register.
// One tick request per cycle when not stalled; state advances once per request.
// Pin changes are spaced by the half period register counted in requests.
// Reset (rst_n low, asynchronous): engine idle, SCL and SDA released,
// half period 500, read byte and ack flag cleared, both stages empty.
`include "assert_macros.svh"

module i2c_byte_master
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  i2cbm_pkg::in_item_t  item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output i2cbm_pkg::out_item_t result
);

    logic                 s1_valid_reg;
    i2cbm_pkg::in_item_t  s1_item_reg;
    logic                 res_valid_reg;
    i2cbm_pkg::out_item_t res_reg;
    i2cbm_pkg::out_item_t eng_result;
    logic                 advance;
    logic                 step;

    // Move when the result register is empty or being taken
    assign advance    = !res_valid_reg || !result_stall;
    assign step       = s1_valid_reg && advance;
    assign item_stall = s1_valid_reg && !advance;

    // Hold the input request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            s1_item_reg <= item;
        end
    end

    i2cbm_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .item      (s1_item_reg),
        .result    (eng_result)
    );

    // Hold the result request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= eng_result;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `ASSERT_CLK(a_stall_when_full, clk, rst_n, (s1_valid_reg && !advance) |-> item_stall)
    `ASSERT_CLK(a_step_fills_result, clk, rst_n, step |=> res_valid_reg)

endmodule
